@@ design/uue_pkg.sv @@
// uue_pkg: constants, types and helpers shared by the uuencode stream block.
// No dependencies; every other design file imports this package.
`default_nettype none

package uue_pkg;

   localparam int LINE_BYTES = 45;                      // bytes per encoded line, 3..63
   localparam int BYTE_W     = 8;
   localparam int FILL_W     = $clog2(LINE_BYTES + 1);  // holds 0..LINE_BYTES
   localparam int ADDR_W     = $clog2(LINE_BYTES);      // line store index
   localparam int POS_W      = FILL_W + 1;              // group position, may run past fill

   localparam logic [7:0] SIX_MASK = 8'h3F;
   localparam logic [7:0] UU_BIAS  = 8'd32;
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_SP  = 8'h20;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } store_wr_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
   } store_rd_type;

   typedef struct packed {
      logic                shift_in;   // append one byte to the group
      logic                take;       // drop the top six bits
      logic [BYTE_W-1:0]   data;
   } slice_ctl_type;

   function automatic logic [7:0] uu_char(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v} & SIX_MASK;
      return w + UU_BIAS;
   endfunction

endpackage

`default_nettype wire

@@ design/uue_ifs.sv @@
// uue_ifs: valid/ready channel interfaces for the uuencode stream block.
// Depends on uue_pkg for field widths.
`default_nettype none

interface uue_req_if;
   import uue_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              byte_valid;
   logic              stream_end;

   modport source (output valid, data_byte, byte_valid, stream_end, input ready);
   modport sink   (input valid, data_byte, byte_valid, stream_end, output ready);
endinterface

interface uue_rsp_if;
   import uue_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_char;
   logic              run_last;
   logic              file_done;

   modport source (output valid, out_char, run_last, file_done, input ready);
   modport sink   (input valid, out_char, run_last, file_done, output ready);
endinterface

`default_nettype wire

@@ design/uue_line_store.sv @@
// uue_line_store: single-write, single-read line buffer with registered read data.
// Depends on uue_pkg.
`default_nettype none

module uue_line_store (
   input  wire                        clock,
   input  uue_pkg::store_wr_type      wr,
   input  uue_pkg::store_rd_type      rd,
   output logic [uue_pkg::BYTE_W-1:0] rd_data
);
   import uue_pkg::*;

   logic [BYTE_W-1:0] mem [LINE_BYTES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

`default_nettype wire

@@ design/uue_slicer.sv @@
// uue_slicer: 24-bit group register shared by all data characters; bytes shift
// in at the bottom, six-bit slices leave from the top. Depends on uue_pkg.
`default_nettype none

module uue_slicer (
   input  wire                    clock,
   input  uue_pkg::slice_ctl_type ctl,
   output logic [7:0]             slice_char
);
   import uue_pkg::*;

   logic [3*BYTE_W-1:0] group_ff;
   logic [3*BYTE_W-1:0] group_in;

   always_comb begin
      group_in = group_ff;
      if (ctl.shift_in) begin
         group_in = {group_ff[2*BYTE_W-1:0], ctl.data};
      end else if (ctl.take) begin
         group_in = {group_ff[3*BYTE_W-7:0], 6'b000000};
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   assign slice_char = uu_char(group_ff[3*BYTE_W-1 -: 6]);

endmodule

`default_nettype wire

@@ design/uuencode_stream.sv @@
// uuencode_stream: top level, line sequencer and output register.
// Depends on uue_pkg, uue_ifs, uue_line_store and uue_slicer.
//
// Streaming uuencoder. Each req transaction carries one file byte (byte_valid)
// and/or the end-of-file mark (stream_end). A byte that does not complete a line
// leaves the block idle and ready for the next request. When the line store fills
// (LINE_BYTES bytes) or the stream ends, the block stops taking requests and emits
// the line one character per rsp transaction: length character, four characters
// per three-byte group, newline; at end of file a space and a final newline follow
// (file_done). Each group is fetched first (three reads of the line store's read
// port, each shifted into the group register as its registered data arrives) and
// then leaves as four slices of the shared slicer. The output register lets the
// next request in while the last character waits.
`default_nettype none

module uuencode_stream (
   input  wire         clock,
   input  wire         reset,
   uue_req_if.sink     req_chan,
   uue_rsp_if.source   rsp_chan
);
   import uue_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LEN, ST_FETCH, ST_EMIT, ST_NL, ST_SP, ST_END_NL
   } state_type;

   state_type         state_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [1:0]        sub_ff;
   logic              end_ff;
   logic              rd_hit_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_char_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;

   logic              accept;
   logic              can_push;
   logic              push;
   logic [FILL_W-1:0] fill_inc;
   logic [POS_W-1:0]  rd_pos;
   logic              rd_in_range;
   logic [POS_W-1:0]  next_pos;
   store_wr_type      store_wr;
   store_rd_type      store_rd;
   logic [BYTE_W-1:0] store_rd_data;
   slice_ctl_type     slice_ctl;
   logic [7:0]        slice_char;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && (state_ff == ST_IDLE);
   assign can_push       = !rsp_valid_ff || rsp_chan.ready;
   // states that load a character into the output register
   assign push           = can_push && (state_ff == ST_LEN || state_ff == ST_EMIT ||
                                        state_ff == ST_NL || state_ff == ST_SP ||
                                        state_ff == ST_END_NL);
   assign fill_inc       = FILL_W'(fill_ff + 1'b1);
   assign rd_pos         = POS_W'(pos_ff + POS_W'(sub_ff));
   assign rd_in_range    = rd_pos < POS_W'(fill_ff);
   assign next_pos       = POS_W'(pos_ff + POS_W'(3));

   always_comb begin
      store_wr.en   = accept && req_chan.byte_valid;
      store_wr.addr = fill_ff[ADDR_W-1:0];
      store_wr.data = req_chan.data_byte;
      store_rd.en   = (state_ff == ST_FETCH) && (sub_ff != 2'd3) && rd_in_range;
      store_rd.addr = rd_pos[ADDR_W-1:0];
   end

   always_comb begin
      slice_ctl.shift_in = (state_ff == ST_FETCH) && (sub_ff != 2'd0);
      slice_ctl.take     = (state_ff == ST_EMIT) && can_push;
      // bytes past the line end pad the group with zeros
      slice_ctl.data     = rd_hit_ff ? store_rd_data : '0;
   end

   uue_line_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (store_rd_data)
   );

   uue_slicer u_slicer (
      .clock      (clock),
      .ctl        (slice_ctl),
      .slice_char (slice_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         pos_ff       <= '0;
         sub_ff       <= '0;
         end_ff       <= 1'b0;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_hit_ff <= store_rd.en;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_chan.byte_valid) begin
                     fill_ff <= fill_inc;
                  end
                  end_ff <= req_chan.stream_end;
                  if (req_chan.byte_valid && fill_inc == FILL_W'(LINE_BYTES)) begin
                     state_ff <= ST_LEN;
                  end else if (req_chan.stream_end) begin
                     if (req_chan.byte_valid || fill_ff != '0) begin
                        state_ff <= ST_LEN;
                     end else begin
                        state_ff <= ST_SP;
                     end
                  end
               end
            end
            ST_LEN: begin
               if (can_push) begin
                  rsp_char_ff  <= uu_char(6'(fill_ff));
                  rsp_last_ff  <= 1'b0;
                  rsp_done_ff  <= 1'b0;
                  pos_ff       <= '0;
                  sub_ff       <= '0;
                  state_ff     <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               // reads issued at sub 0..2, captured in the next sub step
               sub_ff <= sub_ff + 2'd1;
               if (sub_ff == 2'd3) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (can_push) begin
                  rsp_char_ff  <= slice_char;
                  rsp_last_ff  <= 1'b0;
                  rsp_done_ff  <= 1'b0;
                  sub_ff       <= sub_ff + 2'd1;
                  if (sub_ff == 2'd3) begin
                     pos_ff <= next_pos;
                     if (next_pos < POS_W'(fill_ff)) begin
                        state_ff <= ST_FETCH;
                     end else begin
                        state_ff <= ST_NL;
                     end
                  end
               end
            end
            ST_NL: begin
               if (can_push) begin
                  rsp_char_ff  <= CHAR_NL;
                  rsp_last_ff  <= !end_ff;
                  rsp_done_ff  <= 1'b0;
                  fill_ff      <= '0;
                  state_ff     <= end_ff ? ST_SP : ST_IDLE;
               end
            end
            ST_SP: begin
               if (can_push) begin
                  rsp_char_ff  <= CHAR_SP;
                  rsp_last_ff  <= 1'b0;
                  rsp_done_ff  <= 1'b0;
                  state_ff     <= ST_END_NL;
               end
            end
            ST_END_NL: begin
               if (can_push) begin
                  rsp_char_ff  <= CHAR_NL;
                  rsp_last_ff  <= 1'b1;
                  rsp_done_ff  <= 1'b1;
                  end_ff       <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = rsp_char_ff;
   assign rsp_chan.run_last  = rsp_last_ff;
   assign rsp_chan.file_done = rsp_done_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(LINE_BYTES))
      else $error("line fill count past line length");

   a_full_starts_line: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.byte_valid && fill_inc == FILL_W'(LINE_BYTES)
      |=> state_ff == ST_LEN)
      else $error("full line did not start emission");

   a_read_written: assert property (@(posedge clock) disable iff (reset)
      store_rd.en |-> (POS_W'(store_rd.addr) < POS_W'(fill_ff)))
      else $error("line store read beyond written entries");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_last_ff && rsp_char_ff == CHAR_NL)
      else $error("file_done without run_last newline");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_END_NL && can_push |=> state_ff == ST_IDLE && fill_ff == '0)
      else $error("end of file left state behind");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for the uuencode_stream block.
// Depends on uue_pkg and the uue_req_if / uue_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;
   import uue_pkg::*;

   localparam int      HALF_PERIOD = 4;
   localparam longint  RUN_LIMIT   = 64'd8_000_000;   // 8 ms
   localparam int      DRAIN_WAIT  = 130;             // longer than one full line

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       file_done;
   } enc_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   uue_req_if req_chan ();
   uue_rsp_if rsp_chan ();

   uuencode_stream dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // encoder state mirrored by the testbench
   logic [7:0]   line_bytes [LINE_BYTES];
   logic [5:0]   line_fill;
   enc_char_type item_chars[$];
   enc_char_type pending_chars[$];

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int err_count     = 0;

   function automatic logic [7:0] six_to_char(input logic [7:0] v);
      return (v & SIX_MASK) + UU_BIAS;
   endfunction

   function void add_char(input logic [7:0] c, input logic done);
      item_chars.push_back('{c, 1'b0, done});
   endfunction

   function void encode_line();
      int         n;
      logic [7:0] b1, b2, b3;
      n = line_fill;
      add_char(six_to_char(8'(n)), 1'b0);
      for (int i = 0; i < n; i += 3) begin
         b1 = line_bytes[i];
         b2 = (i + 1 < n) ? line_bytes[i + 1] : 8'h00;
         b3 = (i + 2 < n) ? line_bytes[i + 2] : 8'h00;
         add_char(six_to_char(b1 >> 2), 1'b0);
         add_char(six_to_char((b1 << 4) | (b2 >> 4)), 1'b0);
         add_char(six_to_char((b2 << 2) | (b3 >> 6)), 1'b0);
         add_char(six_to_char(b3), 1'b0);
      end
      add_char(CHAR_NL, 1'b0);
      line_fill = '0;
   endfunction

   // expected characters for one accepted transaction
   function void encode_item(input logic [7:0] data, input logic with_byte,
                             input logic end_of_file);
      enc_char_type tail;
      item_chars.delete();
      if (with_byte) begin
         line_bytes[line_fill] = data;
         line_fill = line_fill + 6'd1;
         if (line_fill >= LINE_BYTES)
            encode_line();
      end
      if (end_of_file) begin
         if (line_fill != 0)
            encode_line();
         add_char(CHAR_SP, 1'b0);
         add_char(CHAR_NL, 1'b1);
      end
      if (item_chars.size() > 0) begin
         tail = item_chars.pop_back();
         tail.run_last = 1'b1;
         item_chars.push_back(tail);
      end
      foreach (item_chars[i])
         pending_chars.push_back(item_chars[i]);
   endfunction

   task automatic send_item(input logic [7:0] data, input logic with_byte,
                            input logic end_of_file);
      while ($urandom_range(99) < send_gap_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= data;
      req_chan.byte_valid <= with_byte;
      req_chan.stream_end <= end_of_file;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      encode_item(data, with_byte, end_of_file);
   endtask

   // receiver side: random stall, then compare against the oldest expectation
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      enc_char_type exp_c;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character %h run_last %b file_done %b",
                   rsp_chan.out_char, rsp_chan.run_last, rsp_chan.file_done);
            err_count++;
         end else begin
            exp_c = pending_chars.pop_front();
            if (rsp_chan.out_char !== exp_c.out_char) begin
               $error("out_char: expected %h, got %h", exp_c.out_char, rsp_chan.out_char);
               err_count++;
            end
            if (rsp_chan.run_last !== exp_c.run_last) begin
               $error("run_last: expected %b, got %b", exp_c.run_last, rsp_chan.run_last);
               err_count++;
            end
            if (rsp_chan.file_done !== exp_c.file_done) begin
               $error("file_done: expected %b, got %b", exp_c.file_done, rsp_chan.file_done);
               err_count++;
            end
         end
      end
   end

   // field extremes, partial groups, end-only items and ignored items
   task automatic test_directed();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      send_item(8'hA5, 1'b0, 1'b0);   // neither flag: no output
      send_item(8'h00, 1'b0, 1'b1);   // end with empty line
      send_item(8'hFF, 1'b1, 1'b1);   // one byte, end on the byte
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);   // two bytes
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'hFE, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);   // whole group, closed by an empty item
      send_item(8'h55, 1'b1, 1'b0);
      send_item(8'hAA, 1'b0, 1'b0);   // ignored inside a line
      send_item(8'h33, 1'b1, 1'b0);
      send_item(8'hC3, 1'b1, 1'b0);
      send_item(8'h3C, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b0, 1'b1);   // back-to-back end lines
   endtask

   // lines that fill exactly, with the end on the filling byte or after it
   task automatic test_full_lines();
      send_gap_pct  = 0;
      rsp_stall_pct = 56;
      for (int i = 0; i < LINE_BYTES; i++)
         send_item(8'($urandom_range(255)), 1'b1, i == LINE_BYTES - 1);
      for (int i = 0; i < LINE_BYTES; i++)
         send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // whole files with random length and content, some ignored items mixed in
   task automatic test_random_files(input int n_items, input int gap_pct, input int stall_pct);
      int sent;
      int len;
      int pick;
      bit end_on_byte;
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 55)
            len = $urandom_range(8);
         else if (pick < 85)
            len = $urandom_range(LINE_BYTES + 8, 9);
         else
            len = LINE_BYTES;
         end_on_byte = (len > 0) && ($urandom_range(1) == 1);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8)
               send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
            sent++;
         end
         if (!end_on_byte) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            sent++;
         end
      end
   endtask

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.byte_valid = 1'b0;
      req_chan.stream_end = 1'b0;
      line_fill           = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_lines();
      test_random_files(75, 0, 0);
      test_random_files(75, 56, 0);
      test_random_files(75, 0, 56);
      test_random_files(75, 29, 29);

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (err_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

endmodule
